// File: design/sabv_pkg.sv
// ----------------------------------------------------------------------------
// sabv_pkg
// shared types, fixed widths and the arctangent table of the angle pipeline
// ----------------------------------------------------------------------------
package sabv_pkg;

  localparam int COMPONENT_WIDTH_DEF = 16;
  localparam int ITERATIONS_DEF      = 16;
  localparam int MAX_STAGES          = 24;

  // the larger normalized magnitude lands in [2^29, 2^30) unless both are zero
  localparam int MAG_BITS = 30;
  // cordic datapath: x, y signed, z angle signed q.24
  localparam int XW       = 33;
  localparam int ZW       = 28;
  localparam int ANGLE_W  = 16;

  localparam logic signed [ZW-1:0]      PI_Q24    = 28'sd52707179;
  localparam logic signed [ANGLE_W-1:0] PI_Q13    = 16'sd25736;
  localparam logic signed [ZW-1:0]      RND_HALF  = 28'sd1024;
  localparam int                        RND_SHIFT = 11;

  typedef struct packed {
    logic any_zero;    // one of the vectors is (0,0)
    logic cross_zero;  // cross product is zero
    logic cross_neg;   // cross product is negative
    logic dot_neg;     // dot product is negative
  } flags_t;

  // atan(2^-i) * 2^24, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_q24(input int idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      0:       v = 28'sd13176795;
      1:       v = 28'sd7778716;
      2:       v = 28'sd4110060;
      3:       v = 28'sd2086331;
      4:       v = 28'sd1047214;
      5:       v = 28'sd524117;
      6:       v = 28'sd262123;
      7:       v = 28'sd131069;
      8:       v = 28'sd65536;
      9:       v = 28'sd32768;
      10:      v = 28'sd16384;
      11:      v = 28'sd8192;
      12:      v = 28'sd4096;
      13:      v = 28'sd2048;
      14:      v = 28'sd1024;
      15:      v = 28'sd512;
      16:      v = 28'sd256;
      17:      v = 28'sd128;
      18:      v = 28'sd64;
      19:      v = 28'sd32;
      20:      v = 28'sd16;
      21:      v = 28'sd8;
      22:      v = 28'sd4;
      23:      v = 28'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: design/signed_angle_between_vectors_core.sv
// ----------------------------------------------------------------------------
// signed_angle_between_vectors_core
// signed angle from a first to a second 2-d vector, atan2(cross, dot),
// as a pipelined cordic vectoring chain
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  ----------------------------
//  in       sink       in_valid_i / in_stall_o   first_x/y_i, second_x/y_i
//  out      source     out_valid_o / out_stall_i angle_o (q.13 radians)
//
//  one beat accepted per cycle, sustained while out_stall_i is low; the
//  normalizer and cordic stages are cells, between the front stages and the
//  back register; NW = max(2*CW+1, 30) is the normalizer working width
//  reset clears the valid bit of every stage; payload registers are not reset
//  a stall holds only the stages that are full, bubbles still close up
//
module signed_angle_between_vectors_core #(
  parameter int COMPONENT_WIDTH = sabv_pkg::COMPONENT_WIDTH_DEF,
  parameter int ITERATIONS      = sabv_pkg::ITERATIONS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [COMPONENT_WIDTH-1:0]   first_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0]   first_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0]   second_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0]   second_y_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [sabv_pkg::ANGLE_W-1:0] angle_o
);

  localparam int CW = COMPONENT_WIDTH;
  localparam int PW = 2 * CW + 1;
  // working width of the normalizer, never narrower than the cordic input
  localparam int NW = (PW > sabv_pkg::MAG_BITS) ? PW : sabv_pkg::MAG_BITS;
  localparam int NS = $clog2(NW);
  localparam int NI = (ITERATIONS > sabv_pkg::MAX_STAGES) ? sabv_pkg::MAX_STAGES
                                                          : ITERATIONS;
  localparam int XW = sabv_pkg::XW;
  localparam int ZW = sabv_pkg::ZW;

  // normalizer chain links
  logic [NS:0]       nv, nr;
  logic [NW-1:0]     nc [NS+1];
  logic [NW-1:0]     nd [NS+1];
  sabv_pkg::flags_t  nf [NS+1];

  // cordic chain links
  logic [NI:0]          cv, cr;
  logic signed [XW-1:0] cx [NI+1];
  logic signed [XW-1:0] cy [NI+1];
  logic signed [ZW-1:0] cz [NI+1];
  sabv_pkg::flags_t     cf [NI+1];

  logic front_ready, back_ready, back_valid;

  assign in_stall_o = !front_ready;

  // products, cross and dot magnitudes
  sabv_front #(
    .CW (CW),
    .NW (NW)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (front_ready),
    .x1_i    (first_x_i),
    .y1_i    (first_y_i),
    .x2_i    (second_x_i),
    .y2_i    (second_y_i),
    .valid_o (nv[0]),
    .ready_i (nr[0]),
    .cmag_o  (nc[0]),
    .dmag_o  (nd[0]),
    .flags_o (nf[0])
  );

  // leading-one search, largest shift first; truncation of low bits when
  // the larger magnitude sits above bit 29 matches a floor shift
  for (genvar j = 0; j < NS; j++) begin : g_norm
    sabv_norm_cell #(
      .NW    (NW),
      .SHIFT (1 << (NS - 1 - j))
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (nv[j]),
      .ready_o (nr[j]),
      .cmag_i  (nc[j]),
      .dmag_i  (nd[j]),
      .flags_i (nf[j]),
      .valid_o (nv[j+1]),
      .ready_i (nr[j+1]),
      .cmag_o  (nc[j+1]),
      .dmag_o  (nd[j+1]),
      .flags_o (nf[j+1])
    );
  end

  // top 30 bits of the left-justified magnitudes feed the cordic
  assign cv[0]  = nv[NS];
  assign nr[NS] = cr[0];
  assign cx[0]  = {{(XW - sabv_pkg::MAG_BITS){1'b0}}, nd[NS][NW-1 -: sabv_pkg::MAG_BITS]};
  assign cy[0]  = {{(XW - sabv_pkg::MAG_BITS){1'b0}}, nc[NS][NW-1 -: sabv_pkg::MAG_BITS]};
  assign cz[0]  = '0;
  assign cf[0]  = nf[NS];

  for (genvar i = 0; i < NI; i++) begin : g_cordic
    sabv_cordic_cell #(
      .STAGE (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[i]),
      .ready_o (cr[i]),
      .x_i     (cx[i]),
      .y_i     (cy[i]),
      .z_i     (cz[i]),
      .flags_i (cf[i]),
      .valid_o (cv[i+1]),
      .ready_i (cr[i+1]),
      .x_o     (cx[i+1]),
      .y_o     (cy[i+1]),
      .z_o     (cz[i+1]),
      .flags_o (cf[i+1])
    );
  end

  assign cr[NI] = back_ready;

  // fold, round, sign; doubles as the output register
  sabv_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cv[NI]),
    .ready_o (back_ready),
    .z_i     (cz[NI]),
    .flags_i (cf[NI]),
    .valid_o (back_valid),
    .ready_i (!out_stall_i),
    .angle_o (angle_o)
  );

  assign out_valid_o = back_valid;

endmodule

// File: design/sabv_front.sv
// ----------------------------------------------------------------------------
// sabv_front
// input register, four products, cross and dot magnitudes with sign flags
// ----------------------------------------------------------------------------
module sabv_front #(
  parameter int CW = sabv_pkg::COMPONENT_WIDTH_DEF,
  parameter int NW = sabv_pkg::MAG_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic signed [CW-1:0]   x1_i,
  input  logic signed [CW-1:0]   y1_i,
  input  logic signed [CW-1:0]   x2_i,
  input  logic signed [CW-1:0]   y2_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [NW-1:0]          cmag_o,
  output logic [NW-1:0]          dmag_o,
  output sabv_pkg::flags_t       flags_o
);

  localparam int PW = 2 * CW + 1;

  // stage a: registered components
  logic                va_q;
  logic signed [CW-1:0] x1_q, y1_q, x2_q, y2_q;
  logic                za_q;
  // stage b: products
  logic                vb_q;
  logic signed [2*CW-1:0] p1_q, p2_q, q1_q, q2_q;
  logic                zb_q;
  // stage c: magnitudes
  logic                vc_q;
  logic [NW-1:0]       cmag_q, dmag_q;
  sabv_pkg::flags_t    flags_q;

  logic rdy_a, rdy_b, rdy_c;
  logic za_d;
  logic signed [PW-1:0] cross_d, dot_d;
  logic [PW-1:0]        cmag_d, dmag_d;
  sabv_pkg::flags_t     flags_d;

  assign rdy_c   = !vc_q || ready_i;
  assign rdy_b   = !vb_q || rdy_c;
  assign rdy_a   = !va_q || rdy_b;
  assign ready_o = rdy_a;

  assign za_d = (x1_i == '0 && y1_i == '0) || (x2_i == '0 && y2_i == '0);

  always_comb begin
    cross_d = PW'(p1_q) - PW'(p2_q);
    dot_d   = PW'(q1_q) + PW'(q2_q);
    cmag_d  = cross_d[PW-1] ? -cross_d : cross_d;
    dmag_d  = dot_d[PW-1] ? -dot_d : dot_d;
    flags_d.any_zero   = zb_q;
    flags_d.cross_zero = (cross_d == '0);
    flags_d.cross_neg  = cross_d[PW-1];
    flags_d.dot_neg    = dot_d[PW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      x1_q <= x1_i;
      y1_q <= y1_i;
      x2_q <= x2_i;
      y2_q <= y2_i;
      za_q <= za_d;
    end
    if (rdy_b) begin
      p1_q <= (2*CW)'(x1_q) * (2*CW)'(y2_q);
      p2_q <= (2*CW)'(y1_q) * (2*CW)'(x2_q);
      q1_q <= (2*CW)'(x1_q) * (2*CW)'(x2_q);
      q2_q <= (2*CW)'(y1_q) * (2*CW)'(y2_q);
      zb_q <= za_q;
    end
    if (rdy_c) begin
      cmag_q  <= NW'(cmag_d);
      dmag_q  <= NW'(dmag_d);
      flags_q <= flags_d;
    end
  end

  assign valid_o = vc_q;
  assign cmag_o  = cmag_q;
  assign dmag_o  = dmag_q;
  assign flags_o = flags_q;

endmodule

// File: design/sabv_norm_cell.sv
// ----------------------------------------------------------------------------
// sabv_norm_cell
// one step of the leading-one normalizer: shifts both magnitudes left by a
// fixed power of two when the top bits of both are clear
// ----------------------------------------------------------------------------
module sabv_norm_cell #(
  parameter int NW    = sabv_pkg::MAG_BITS,
  parameter int SHIFT = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [NW-1:0]    cmag_i,
  input  logic [NW-1:0]    dmag_i,
  input  sabv_pkg::flags_t flags_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [NW-1:0]    cmag_o,
  output logic [NW-1:0]    dmag_o,
  output sabv_pkg::flags_t flags_o
);

  logic             valid_q;
  logic [NW-1:0]    cmag_q, dmag_q;
  sabv_pkg::flags_t flags_q;
  logic [NW-1:0]    both;
  logic             top_clear;

  assign ready_o   = !valid_q || ready_i;
  assign both      = cmag_i | dmag_i;
  assign top_clear = (both[NW-1 -: SHIFT] == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      cmag_q  <= top_clear ? (cmag_i << SHIFT) : cmag_i;
      dmag_q  <= top_clear ? (dmag_i << SHIFT) : dmag_i;
      flags_q <= flags_i;
    end
  end

  assign valid_o = valid_q;
  assign cmag_o  = cmag_q;
  assign dmag_o  = dmag_q;
  assign flags_o = flags_q;

endmodule

// File: design/sabv_cordic_cell.sv
// ----------------------------------------------------------------------------
// sabv_cordic_cell
// one cordic vectoring micro-rotation with a fixed shift and table angle
// ----------------------------------------------------------------------------
module sabv_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic signed [sabv_pkg::XW-1:0]    x_i,
  input  logic signed [sabv_pkg::XW-1:0]    y_i,
  input  logic signed [sabv_pkg::ZW-1:0]    z_i,
  input  sabv_pkg::flags_t                  flags_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic signed [sabv_pkg::XW-1:0]    x_o,
  output logic signed [sabv_pkg::XW-1:0]    y_o,
  output logic signed [sabv_pkg::ZW-1:0]    z_o,
  output sabv_pkg::flags_t                  flags_o
);

  localparam logic signed [sabv_pkg::ZW-1:0] ANGLE = sabv_pkg::atan_q24(STAGE);

  logic                           valid_q;
  logic signed [sabv_pkg::XW-1:0] x_q, y_q, xs, ys;
  logic signed [sabv_pkg::ZW-1:0] z_q;
  sabv_pkg::flags_t               flags_q;

  assign ready_o = !valid_q || ready_i;
  assign xs      = x_i >>> STAGE;
  assign ys      = y_i >>> STAGE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // rotate toward the x axis
  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      if (!y_i[sabv_pkg::XW-1]) begin
        x_q <= x_i + ys;
        y_q <= y_i - xs;
        z_q <= z_i + ANGLE;
      end else begin
        x_q <= x_i - ys;
        y_q <= y_i + xs;
        z_q <= z_i - ANGLE;
      end
      flags_q <= flags_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign flags_o = flags_q;

endmodule

// File: design/sabv_back.sv
// ----------------------------------------------------------------------------
// sabv_back
// half-plane fold, rounding to q.13, sign and special cases; output register
// ----------------------------------------------------------------------------
module sabv_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic signed [sabv_pkg::ZW-1:0]        z_i,
  input  sabv_pkg::flags_t                      flags_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic signed [sabv_pkg::ANGLE_W-1:0]   angle_o
);

  localparam int ZW = sabv_pkg::ZW;
  localparam int AW = sabv_pkg::ANGLE_W;
  localparam int RW = ZW - sabv_pkg::RND_SHIFT;

  logic                 valid_q;
  logic signed [AW-1:0] angle_q, angle_d;
  logic signed [ZW-1:0] zc, zf, zr;
  logic [RW-1:0]        res;
  logic signed [AW-1:0] mag;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    zc = z_i[ZW-1] ? '0 : z_i;
    zf = zc;
    if (flags_i.dot_neg) begin
      zf = sabv_pkg::PI_Q24 - zc;
      if (zf[ZW-1]) zf = '0;
    end
    zr  = zf + sabv_pkg::RND_HALF;
    res = zr[ZW-1:sabv_pkg::RND_SHIFT];
    if (res > RW'(sabv_pkg::PI_Q13)) begin
      mag = sabv_pkg::PI_Q13;
    end else begin
      mag = AW'(res);
    end
    priority if (flags_i.any_zero) begin
      angle_d = '0;
    end else if (flags_i.cross_zero) begin
      angle_d = flags_i.dot_neg ? sabv_pkg::PI_Q13 : '0;
    end else begin
      angle_d = flags_i.cross_neg ? -mag : mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      angle_q <= angle_d;
    end
  end

  assign valid_o = valid_q;
  assign angle_o = angle_q;

endmodule
